@@ rtl/core/open_addressing_word_table_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the word table core
// Concurrent checks sampled on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESSING_WORD_TABLE_CORE_ASSERT_SVH
`define OPEN_ADDRESSING_WORD_TABLE_CORE_ASSERT_SVH

// check cons in the same cycle as ante
`define OWT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante
`define OWT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/owt_pkg.sv @@
// ----------------------------------------------------------------------------
// owt_pkg
// Transaction types, table entry layout and fixed constants of the word table.
// ----------------------------------------------------------------------------
package owt_pkg;

	localparam int KEY_W      = 16;
	localparam int CHARS_W    = 64;
	localparam int LEN_W      = 4;
	localparam int SLOT_W     = 6;
	localparam int CHAR_W     = 8;
	localparam int CHAR_COUNT = CHARS_W / CHAR_W;
	localparam int HASH_MULT  = 7;
	localparam int HASH_W     = KEY_W + 3;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	typedef struct packed {
		logic               command;
		logic [KEY_W-1:0]   key;
		logic [CHARS_W-1:0] word_chars;
		logic [LEN_W-1:0]   word_length;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
		logic              inserted;
		logic              table_full;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [LEN_W-1:0]   length;
		logic [CHARS_W-1:0] chars;
	} entry_t;

endpackage

@@ rtl/core/owt_ram.sv @@
// ----------------------------------------------------------------------------
// owt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module owt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/open_addressing_word_table_core.sv @@
// ----------------------------------------------------------------------------
// open_addressing_word_table_core
// Open-addressing word table: lookup or insert-if-absent, fixed-step probing.
// ----------------------------------------------------------------------------
// After reset the block sweeps the valid map, one slot per cycle, with
// req_ready low. Each accepted request then passes through these states in
// order: ST_MUL1, ST_MUL2 and ST_FIX compute the home slot (key * 7) mod
// TABLE_SIZE by reciprocal multiplication and correction, both products on
// one shared multiplier; ST_READ starts the first read; ST_CHECK, the probe
// loop, reads one slot per cycle through the RAM read port; and ST_RESP
// hands the result to the output register. A result still waiting in the
// output register does not hold off the next request; that request's own
// result waits in ST_RESP until the output register is free.
// ----------------------------------------------------------------------------
module open_addressing_word_table_core #(
	parameter int TABLE_SIZE     = 64,
	parameter int PROBE_STEP     = 4,
	parameter int MAX_WORD_CHARS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  owt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output owt_pkg::rsp_t rsp
);

	localparam int IDX_W    = $clog2(TABLE_SIZE);
	localparam int HASH_W   = owt_pkg::HASH_W;
	localparam int RECIP_W  = HASH_W + 1;
	localparam int PROD_W   = HASH_W + RECIP_W;
	localparam int SHIFT    = HASH_W + IDX_W;
	localparam logic [63:0] RECIP64 = (64'd1 << SHIFT) / TABLE_SIZE;
	localparam int STEP_MOD = PROBE_STEP % TABLE_SIZE;
	localparam int ENTRY_W  = $bits(owt_pkg::entry_t);
	localparam int LEN_W_SAT = owt_pkg::LEN_W;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MUL1  = 3'd2;
	localparam logic [2:0] ST_MUL2  = 3'd3;
	localparam logic [2:0] ST_FIX   = 3'd4;
	localparam logic [2:0] ST_READ  = 3'd5;
	localparam logic [2:0] ST_CHECK = 3'd6;
	localparam logic [2:0] ST_RESP  = 3'd7;

	logic [2:0]             state_q;
	logic [IDX_W-1:0]       clr_q;
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       home_q;
	logic [HASH_W-1:0]      x_q;
	logic [PROD_W-1:0]      prod_q;
	owt_pkg::entry_t        req_q;
	logic                   cmd_q;
	owt_pkg::rsp_t          res_q;
	owt_pkg::rsp_t          res_nxt;
	owt_pkg::rsp_t          rsp_q;
	logic                   rsp_valid_q;

	logic [LEN_W_SAT-1:0]   len_sat;
	logic [owt_pkg::CHARS_W-1:0] chars_masked;

	logic [HASH_W-1:0]      mul_a;
	logic [RECIP_W-1:0]     mul_b;
	logic [PROD_W-1:0]      mul_p;
	logic [PROD_W-1:0]      quot_full;
	logic [IDX_W:0]         rem;
	logic [IDX_W:0]         rem_fix;
	logic [IDX_W:0]         nxt_sum;
	logic [IDX_W-1:0]       nxt_idx;
	logic [IDX_W+owt_pkg::SLOT_W-1:0] idx_wide;
	logic [owt_pkg::SLOT_W-1:0] slot_low;

	logic [IDX_W-1:0]       rd_addr;
	logic [ENTRY_W-1:0]     ent_rd;
	owt_pkg::entry_t        ent;
	logic [0:0]             vld_rd;
	logic                   ent_we;
	logic                   vld_we;
	logic [IDX_W-1:0]       vld_waddr;
	logic [0:0]             vld_wdata;
	logic                   hit;
	logic                   rsp_free;

	always_comb begin
		len_sat = req.word_length;
		if (req.word_length > LEN_W_SAT'(MAX_WORD_CHARS)) begin
			len_sat = LEN_W_SAT'(MAX_WORD_CHARS);
		end
		chars_masked = req.word_chars;
		for (int i = 0; i < owt_pkg::CHAR_COUNT; i++) begin
			if (LEN_W_SAT'(i) >= len_sat) begin
				chars_masked[i*owt_pkg::CHAR_W +: owt_pkg::CHAR_W] = '0;
			end
		end
	end

	always_comb begin
		mul_a = x_q;
		mul_b = RECIP64[RECIP_W-1:0];
		if (state_q == ST_MUL2) begin
			mul_a = quot_full[HASH_W-1:0];
			mul_b = RECIP_W'(TABLE_SIZE);
		end
	end

	assign mul_p     = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign quot_full = prod_q >> SHIFT;

	always_comb begin
		rem     = (IDX_W+1)'(PROD_W'(x_q) - prod_q);
		rem_fix = rem;
		if (rem >= (IDX_W+1)'(TABLE_SIZE)) begin
			rem_fix = rem - (IDX_W+1)'(TABLE_SIZE);
		end
	end

	always_comb begin
		nxt_sum = {1'b0, idx_q} + (IDX_W+1)'(STEP_MOD);
		if (nxt_sum >= (IDX_W+1)'(TABLE_SIZE)) begin
			nxt_sum = nxt_sum - (IDX_W+1)'(TABLE_SIZE);
		end
		nxt_idx = nxt_sum[IDX_W-1:0];
	end

	assign idx_wide = {{owt_pkg::SLOT_W{1'b0}}, idx_q};
	assign slot_low = idx_wide[owt_pkg::SLOT_W-1:0];

	assign ent = owt_pkg::entry_t'(ent_rd);
	assign hit = vld_rd[0] && ent.key == req_q.key && ent.length == req_q.length &&
		ent.chars == req_q.chars;

	always_comb begin
		res_nxt = '0;
		if (!vld_rd[0]) begin
			if (cmd_q == owt_pkg::CMD_INSERT) begin
				res_nxt.inserted = 1'b1;
				res_nxt.slot     = slot_low;
			end
		end else if (hit) begin
			res_nxt.found = 1'b1;
			res_nxt.slot  = slot_low;
		end else if (nxt_idx == home_q) begin
			res_nxt.table_full = (cmd_q == owt_pkg::CMD_INSERT);
		end
	end

	assign rd_addr   = (state_q == ST_CHECK) ? nxt_idx : idx_q;
	assign ent_we    = (state_q == ST_CHECK) && !vld_rd[0] && cmd_q == owt_pkg::CMD_INSERT;
	assign vld_we    = (state_q == ST_CLEAR) || ent_we;
	assign vld_waddr = (state_q == ST_CLEAR) ? clr_q : idx_q;
	assign vld_wdata = (state_q == ST_CLEAR) ? 1'b0 : 1'b1;

	owt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_SIZE)
	) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(idx_q),
		.wdata(ENTRY_W'(req_q)),
		.raddr(rd_addr),
		.rdata(ent_rd)
	);

	owt_ram #(
		.WIDTH(1),
		.DEPTH(TABLE_SIZE)
	) u_valid_ram (
		.clk  (clk),
		.we   (vld_we),
		.waddr(vld_waddr),
		.wdata(vld_wdata),
		.raddr(rd_addr),
		.rdata(vld_rd)
	);

	assign rsp_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_RESP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(TABLE_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_FIX;
				ST_FIX:  state_q <= ST_READ;
				ST_READ: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (!vld_rd[0] || hit || nxt_idx == home_q) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd_q <= req.command;
					req_q <= '{key: req.key, length: len_sat, chars: chars_masked};
					x_q   <= HASH_W'(req.key) * HASH_W'(owt_pkg::HASH_MULT);
				end
			end
			ST_MUL1: prod_q <= mul_p;
			ST_MUL2: prod_q <= mul_p;
			ST_FIX: begin
				idx_q  <= rem_fix[IDX_W-1:0];
				home_q <= rem_fix[IDX_W-1:0];
			end
			ST_CHECK: begin
				res_q <= res_nxt;
				if (vld_rd[0] && !hit && nxt_idx != home_q) begin
					idx_q <= nxt_idx;
				end
			end
			ST_RESP: begin
				if (rsp_free) begin
					rsp_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/core/owt_checker.sv @@
// ----------------------------------------------------------------------------
// owt_checker
// Port-level checks of the word table core, bound to its top level.
// ----------------------------------------------------------------------------
`include "open_addressing_word_table_core_assert.svh"

module owt_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input owt_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input owt_pkg::rsp_t rsp
);

	`OWT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp moved")
	`OWT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "req_ready high")
	`OWT_ASSERT_SAME(a_flags_exclusive, rsp_valid, !(rsp.found && rsp.inserted), "flag clash")
	`OWT_ASSERT_SAME(a_full_alone, rsp_valid && rsp.table_full, !rsp.found, "full with found")
	`OWT_ASSERT_SAME(a_miss_slot_zero, rsp_valid && !rsp.found && !rsp.inserted, rsp.slot == '0, "slot")

endmodule

bind open_addressing_word_table_core owt_checker u_owt_checker (.*);
